// File: sv/wgm_pkg.sv
package wgm_pkg;

	localparam int PAT_BYTES = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int LEN_REG_W = 6;

	localparam logic [7:0] ANY_ONE_CHAR = 8'h3F;
	localparam logic [7:0] ANY_RUN_CHAR = 8'h2A;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	typedef enum logic [2:0] {
		REG_CHARS_0 = 3'd0,
		REG_CHARS_1 = 3'd1,
		REG_CHARS_2 = 3'd2,
		REG_CHARS_3 = 3'd3,
		REG_LENGTH = 3'd4
	} reg_idx_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

// File: sv/wildcard_glob_matcher_unit.sv
// channel   dir  payload                          transfer when
// s_axis    in   tdata=text_char tuser=has_char   s_axis_tvalid & s_axis_tready
//                tlast=last_char
// m_axis    out  tdata[0]=matched                 m_axis_tvalid & m_axis_tready
// apb       in   pattern registers, 8-byte stride psel & penable & pwrite
//
// One character per cycle: an input register, then one pass of star closure,
// position step and second closure (two 33-bit carry chains) into the state
// and result registers. Only a string-ending character waits for a full result
// register; other characters keep flowing. Reset leaves position zero active
// and the pattern empty.
module wildcard_glob_matcher_unit
	import wgm_pkg::*;
#(
	parameter int PATTERN_MAX = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] text_char
	input  logic                  s_axis_tuser,   // [0] has_char
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,   // [0] matched, [7:1] zero
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int W = PATTERN_MAX + 1;
	localparam int LW = $clog2(W);

	logic [CFG_DATA_W-1:0] chars_q [4];
	logic [LEN_REG_W-1:0]  length_q;
	logic [W-1:0]          active_q;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       has_s1;
	logic       last_s1;

	logic       m_valid_q;
	logic       matched_q;

	logic                 out_free;
	logic                 adv;
	logic                 cfg_wr;
	logic [LW-1:0]        len_eff;
	logic [W-1:0]         len_mask;
	logic [W-1:0]         star_vec;
	logic [8*PAT_BYTES-1:0] pat_flat;
	logic [W-1:0]         closed_in;
	logic [W-1:0]         stepped;
	logic [W-1:0]         closed_out;
	logic [W-1:0]         cand;

	function automatic logic [W-1:0] close_stars(input logic [W-1:0] set,
		input logic [W-1:0] mask, input logic [W-1:0] star);
		logic [W-1:0] s;
		logic [W-1:0] g;
		logic [W-1:0] carries;
		s = set & mask;
		g = s & star;
		carries = (g + star) ^ g ^ star;
		return s | (carries & mask);
	endfunction

	assign pat_flat = {chars_q[3], chars_q[2], chars_q[1], chars_q[0]};
	assign len_eff = (length_q > LEN_REG_W'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
		: length_q[LW-1:0];

	always_comb begin
		len_mask = '0;
		star_vec = '0;
		for (int i = 0; i < W; i++) begin
			len_mask[i] = (LW'(i) <= len_eff);
		end
		for (int i = 0; i < PATTERN_MAX; i++) begin
			star_vec[i] = (LW'(i) < len_eff) && (pat_flat[8*i +: 8] == ANY_RUN_CHAR);
		end
	end

	assign closed_in = close_stars(active_q, len_mask, star_vec);

	always_comb begin
		logic [7:0] p;
		stepped = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			p = pat_flat[8*i +: 8];
			if (closed_in[i] && LW'(i) < len_eff) begin
				if (p == ANY_RUN_CHAR) begin
					stepped[i] = 1'b1;
				end else if (p == ANY_ONE_CHAR) begin
					if (char_s1 != DOT_CHAR) begin
						stepped[i+1] = 1'b1;
					end
				end else if (fold_case(p) == fold_case(char_s1)) begin
					stepped[i+1] = 1'b1;
				end
			end
		end
	end

	assign closed_out = close_stars(stepped, len_mask, star_vec);
	assign cand = has_s1 ? closed_out : closed_in;

	assign out_free = !m_valid_q || m_axis_tready;
	assign adv = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			has_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= W'(1);
		end else if (adv) begin
			if (last_s1) begin
				active_q <= W'(1);
			end else if (has_s1) begin
				active_q <= closed_out;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			matched_q <= cand[len_eff];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {7'd0, matched_q};

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q[0] <= '0;
			chars_q[1] <= '0;
			chars_q[2] <= '0;
			chars_q[3] <= '0;
			length_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[5:3]))
				REG_CHARS_0: chars_q[0] <= pwdata;
				REG_CHARS_1: chars_q[1] <= pwdata;
				REG_CHARS_2: chars_q[2] <= pwdata;
				REG_CHARS_3: chars_q[3] <= pwdata;
				REG_LENGTH:  length_q <= pwdata[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[5:3]))
			REG_CHARS_0: prdata = chars_q[0];
			REG_CHARS_1: prdata = chars_q[1];
			REG_CHARS_2: prdata = chars_q[2];
			REG_CHARS_3: prdata = chars_q[3];
			REG_LENGTH:  prdata = CFG_DATA_W'(length_q);
			default:     prdata = '0;
		endcase
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> active_q == W'(1))
		else $error("position set not restarted after string end");

	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && last_s1 && m_valid_q && !m_axis_tready)
		else $error("input stalled without a pending string end");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(adv && last_s1))
		else $error("result appeared without a string end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |-> !(adv && last_s1))
		else $error("pending result overwritten");

endmodule

// File: sim/tb_wildcard_glob_matcher_unit.sv
`timescale 1ns / 100ps

import wgm_pkg::*;

class glob_scoreboard;
	logic [7:0]  pat_bytes [PAT_BYTES];
	logic [5:0]  len_reg;
	logic [32:0] reach;
	bit          match_q [$];
	int unsigned errors;

	function new();
		foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
		len_reg = '0;
		reach = 33'd1;
		errors = 0;
	endfunction

	function void set_reg(reg_idx_t idx, logic [63:0] value);
		if (idx == REG_LENGTH) begin
			len_reg = value[5:0];
		end else begin
			for (int b = 0; b < 8; b++) pat_bytes[int'(idx) * 8 + b] = value[8 * b +: 8];
		end
	endfunction

	function int unsigned eff_len();
		return (len_reg > PAT_BYTES) ? PAT_BYTES : len_reg;
	endfunction

	function logic [7:0] upcase(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function logic [32:0] star_close(logic [32:0] s, int unsigned n);
		logic [32:0] r;
		r = s;
		for (int i = 0; i <= 32; i++) if (i > n) r[i] = 1'b0;
		for (int i = 0; i < n; i++) if (r[i] && pat_bytes[i] == ANY_RUN_CHAR) r[i + 1] = 1'b1;
		return r;
	endfunction

	function logic [32:0] step_char(logic [32:0] s, logic [7:0] c, int unsigned n);
		logic [32:0] cur;
		logic [32:0] nxt;
		cur = star_close(s, n);
		nxt = '0;
		for (int i = 0; i < n; i++) begin
			if (cur[i]) begin
				if (pat_bytes[i] == ANY_RUN_CHAR) begin
					nxt[i] = 1'b1;
				end else if (pat_bytes[i] == ANY_ONE_CHAR) begin
					if (c != DOT_CHAR) nxt[i + 1] = 1'b1;
				end else if (upcase(pat_bytes[i]) == upcase(c)) begin
					nxt[i + 1] = 1'b1;
				end
			end
		end
		return star_close(nxt, n);
	endfunction

	function void note_input(logic [7:0] c, bit has, bit last);
		int unsigned n;
		logic [32:0] s;
		n = eff_len();
		if (has) reach = step_char(reach, c, n);
		if (last) begin
			s = star_close(reach, n);
			match_q.insert(match_q.size(), s[n]);
			reach = 33'd1;
		end
	endfunction

	function void check_result(bit matched);
		bit want;
		if (match_q.size() == 0) begin
			$error("matched: expected none, actual %0b", matched);
			errors++;
		end else begin
			want = match_q.pop_front();
			if (want != matched) begin
				$error("matched: expected %0b, actual %0b", want, matched);
				errors++;
			end
		end
	endfunction

	function int pending();
		return match_q.size();
	endfunction
endclass

module tb_wildcard_glob_matcher_unit;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 550;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;   // [7:0] text_char
	logic                  s_axis_tuser;   // [0] has_char
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;   // [0] matched, [7:1] zero
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	glob_scoreboard sb;
	int unsigned    src_max_gap;
	int unsigned    snk_max_stall;
	int unsigned    chars_sent;
	int unsigned    idle_cycles;
	logic [7:0]     text_buf [$];
	logic [7:0]     pat_buf [PAT_BYTES];
	logic [5:0]     len_val;

	wildcard_glob_matcher_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(int'(idx) * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_pattern(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
			logic [63:0] c3, logic [5:0] len);
		write_reg(REG_CHARS_0, c0);
		write_reg(REG_CHARS_1, c1);
		write_reg(REG_CHARS_2, c2);
		write_reg(REG_CHARS_3, c3);
		write_reg(REG_LENGTH, {58'd0, len});
	endtask

	// block is idle only once every result is out and the pipeline has drained
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_char(logic [7:0] c, bit has, bit last);
		int unsigned gap;
		gap = $urandom_range(0, src_max_gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tuser <= has;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(c, has, last);
		chars_sent++;
	endtask

	// end_item: close the string with a separate has_char = 0 transfer
	task automatic send_text(bit end_item, bit idle_noise);
		int unsigned n;
		n = text_buf.size();
		if (n == 0) begin
			push_char(8'($urandom), 1'b0, 1'b1);
		end else begin
			for (int i = 0; i < n; i++) begin
				if (idle_noise && $urandom_range(0, 9) == 0)
					push_char(8'($urandom), 1'b0, 1'b0);
				push_char(text_buf[i], 1'b1, (i == n - 1) && !end_item);
			end
			if (end_item) push_char(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	function automatic logic [7:0] rand_char();
		logic [7:0] c;
		case ($urandom_range(0, 11))
			0, 1: c = 8'h61 + 8'($urandom_range(0, 3));
			2, 3: c = 8'h41 + 8'($urandom_range(0, 3));
			4: c = DOT_CHAR;
			5: c = ANY_RUN_CHAR;
			6: c = ANY_ONE_CHAR;
			7: c = 8'h00;
			8: c = 8'hFF;
			9: c = ($urandom_range(0, 1) != 0) ? 8'h40 : 8'h60;
			default: c = 8'($urandom);
		endcase
		return c;
	endfunction

	task automatic random_setting();
		logic [63:0] regs [4];
		int unsigned n;
		case ($urandom_range(0, 9))
			0: len_val = 6'd0;
			1: len_val = ($urandom_range(0, 1) != 0) ? 6'd32 : 6'd63;
			2: len_val = 6'($urandom_range(9, 63));
			default: len_val = 6'($urandom_range(1, 8));
		endcase
		n = (len_val > PAT_BYTES) ? PAT_BYTES : len_val;
		foreach (pat_buf[i]) pat_buf[i] = (i < n) ? rand_char() : 8'($urandom);
		for (int r = 0; r < 4; r++) begin
			for (int b = 0; b < 8; b++) regs[r][8 * b +: 8] = pat_buf[8 * r + b];
			if (r * 8 >= n) begin
				case ($urandom_range(0, 3))
					0: regs[r] = '0;
					1: regs[r] = '1;
					default: ;
				endcase
			end
		end
		write_pattern(regs[0], regs[1], regs[2], regs[3], len_val);
		src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
		snk_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 4;
	endtask

	// mostly strings built to fit the pattern, some damaged, some random
	task automatic make_text();
		int unsigned n;
		logic [7:0] p;
		logic [7:0] c;
		text_buf.delete();
		n = (len_val > PAT_BYTES) ? PAT_BYTES : len_val;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(0, 6)) text_buf.insert(text_buf.size(), rand_char());
		end else begin
			for (int i = 0; i < n; i++) begin
				p = pat_buf[i];
				if (p == ANY_RUN_CHAR) begin
					repeat ($urandom_range(0, 3))
						text_buf.insert(text_buf.size(), rand_char());
				end else if (p == ANY_ONE_CHAR) begin
					c = rand_char();
					text_buf.insert(text_buf.size(), (c == DOT_CHAR) ? 8'h78 : c);
				end else begin
					if (((p >= 8'h61 && p <= 8'h7A) || (p >= 8'h41 && p <= 8'h5A))
							&& $urandom_range(0, 1) != 0)
						p = p ^ 8'h20;
					text_buf.insert(text_buf.size(), p);
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 2))
					0: if (text_buf.size() > 0)
						text_buf[$urandom_range(0, text_buf.size() - 1)] = rand_char();
					1: text_buf.insert($urandom_range(0, text_buf.size()), rand_char());
					default: if (text_buf.size() > 0)
						text_buf.delete($urandom_range(0, text_buf.size() - 1));
				endcase
			end
		end
	endtask

	initial begin
		sb = new();
		src_max_gap = 4;
		snk_max_stall = 4;
		chars_sent = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		s_axis_tlast <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern: empty, so only the empty string matches
		push_char(8'h5A, 1'b0, 1'b1);
		push_char(8'h33, 1'b0, 1'b0);
		push_char(8'h61, 1'b1, 1'b1);
		drain();

		// "a?C**": trailing star run, dot against '?', case folding
		write_pattern(64'hFFFFFF2A2A433F61, 64'h0, 64'h0, 64'h0, 6'd5);
		text_buf = '{8'h41, 8'h62, 8'h43};
		send_text(1'b0, 1'b0);
		text_buf = '{8'h61, 8'h2E, 8'h63};
		send_text(1'b0, 1'b0);
		text_buf = '{8'h61, 8'h62, 8'h63, 8'h78, 8'h79, 8'h7A};
		send_text(1'b0, 1'b0);
		text_buf.delete();
		send_text(1'b0, 1'b0);
		drain();

		// zero bytes as literals, 0xFF bytes, separate end transfer
		write_pattern(64'h0000000000FF2A00, '1, '1, '1, 6'd3);
		text_buf = '{8'h00, 8'h41, 8'hFF};
		send_text(1'b0, 1'b0);
		text_buf = '{8'h00, 8'hFF};
		send_text(1'b1, 1'b0);
		drain();

		// length above the maximum clips to 32
		write_pattern({8{ANY_RUN_CHAR}}, {8{ANY_RUN_CHAR}}, {8{ANY_RUN_CHAR}},
			{8'h7A, {7{ANY_RUN_CHAR}}}, 6'd63);
		text_buf = '{8'h5A};
		send_text(1'b0, 1'b0);
		text_buf = '{8'h61, 8'h7A};
		send_text(1'b0, 1'b0);
		drain();
		write_reg(REG_CHARS_3, {8{ANY_RUN_CHAR}});
		write_reg(REG_LENGTH, 64'd32);
		push_char(8'h00, 1'b0, 1'b1);
		drain();

		while (chars_sent < ITEM_TARGET) begin
			random_setting();
			repeat ($urandom_range(4, 10)) begin
				if (chars_sent < ITEM_TARGET) begin
					make_text();
					send_text($urandom_range(0, 5) == 0, 1'b1);
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("** wildcard_glob_matcher_unit: PASSED **");
		end else begin
			$display("** wildcard_glob_matcher_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		int unsigned stall;
		m_axis_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = $urandom_range(0, snk_max_stall);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata[0]);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("** wildcard_glob_matcher_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
